[rtl/core/kci_pkg.sv]
// Shared widths, codes and types for the keyframe colour interpolator.
`timescale 1ns / 1ps

package kci_pkg;

    localparam int LEVEL_W       = 8;
    localparam int POS_W         = 22;
    localparam int DUR_W         = 16;
    localparam int COUNT_W       = 7;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 6;
    localparam int DELTA_W       = 16;
    localparam int COLOUR_FIELDS = 5;
    localparam int BLEND_STEPS   = 8;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int CHANNELS_DEF   = 5;

    localparam logic [POS_W-1:0]   POS_MAX     = 22'h3FFFFF;
    localparam logic [DUR_W-1:0]   DUR_RESET   = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'hFF;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_FRAME_SPAN  = 1'b1;

    typedef struct packed {
        logic mul;
        logic step;
    } lane_ctrl_t;

endpackage

[rtl/core/keyframe_colour_interpolator.sv]
// Keyframe colour player: frame memory, timeline sequencer and blend lanes.
//
// A keyframe write, a start or an unused op is done in the cycle it is accepted. A tick
// holds the input until ready returns, through these steps: acceptance, the end of the
// timeline, one compare, one restoring step per frame-index bit to split the position
// into frame and offset, two reads of the single-port frame memory, one multiply and
// eight divide steps in the per-channel lanes, and the load of the result word. A tick
// at or past the end of the timeline skips the split. The load waits while the previous
// result word has not been accepted. After reset the frame memory is filled with magenta
// over all MAX_FRAMES entries, during which no input word is taken; configuration writes
// are taken at any time.
`timescale 1ns / 1ps

module keyframe_colour_interpolator
    import kci_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [DUR_W-1:0]   cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_op,
    input  logic [IDX_W-1:0]   s_frame_index,
    input  logic [LEVEL_W-1:0] s_red,
    input  logic [LEVEL_W-1:0] s_green,
    input  logic [LEVEL_W-1:0] s_blue,
    input  logic [LEVEL_W-1:0] s_white_one,
    input  logic [LEVEL_W-1:0] s_white_two,
    input  logic [DELTA_W-1:0] s_delta_ms,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_out_red,
    output logic [LEVEL_W-1:0] m_out_green,
    output logic [LEVEL_W-1:0] m_out_blue,
    output logic [LEVEL_W-1:0] m_out_white_one,
    output logic [LEVEL_W-1:0] m_out_white_two,
    output logic               m_still_running,
    output logic [POS_W-1:0]   m_position_ms
);

    localparam int AW     = $clog2(MAX_FRAMES);
    localparam int DW     = CHANNELS * LEVEL_W;
    localparam int MUL_W  = AW + DUR_W;
    localparam int STEP_W = $clog2(((AW > BLEND_STEPS) ? AW : BLEND_STEPS) + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_END,
        ST_CMP,
        ST_DIV,
        ST_RDA,
        ST_RDB,
        ST_MUL,
        ST_BLEND,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DUR_W-1:0]   duration_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               run_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [POS_W-1:0]   end_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [AW-1:0]      last_reg;
    logic               at_end_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [AW-1:0]      fi_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [AW-1:0]      clr_reg;
    logic [DW-1:0]      frame_a_reg;

    logic               m_valid_reg;
    logic [LEVEL_W-1:0] m_colour_reg [COLOUR_FIELDS];
    logic               m_running_reg;
    logic [POS_W-1:0]   m_position_reg;

    logic [AW-1:0]      last_w;
    logic [DUR_W-1:0]   dur_w;
    logic [MUL_W-1:0]   end_prod;
    logic [POS_W-1:0]   end_w;
    logic [DUR_W:0]     trial;
    logic [DUR_W:0]     sub;
    logic               fits;
    logic [POS_W:0]     sum;
    logic               over;
    logic [POS_W-1:0]   pos_next;
    logic               run_next;
    logic               out_free;
    logic               write_ok;

    logic [LEVEL_W-1:0] in_lvl [COLOUR_FIELDS];
    logic [DW-1:0]      write_word;
    logic [DW-1:0]      magenta_word;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [DW-1:0]      mem_wdata;
    logic [DW-1:0]      mem_rdata;

    lane_ctrl_t         lane_ctrl;
    logic [LEVEL_W-1:0] lane_lvl [CHANNELS];
    logic [LEVEL_W-1:0] colour   [COLOUR_FIELDS];

    assign in_lvl[0] = s_red;
    assign in_lvl[1] = s_green;
    assign in_lvl[2] = s_blue;
    assign in_lvl[3] = s_white_one;
    assign in_lvl[4] = s_white_two;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (c < COLOUR_FIELDS) begin
                write_word[c*LEVEL_W +: LEVEL_W] = in_lvl[c];
            end else begin
                write_word[c*LEVEL_W +: LEVEL_W] = '0;
            end
            if (c == 0 || (CHANNELS > 2 && c == 2)) begin
                magenta_word[c*LEVEL_W +: LEVEL_W] = LEVEL_FULL;
            end else begin
                magenta_word[c*LEVEL_W +: LEVEL_W] = '0;
            end
        end
    end

    always_comb begin
        if (count_reg == '0) begin
            last_w = '0;
        end else if ({25'b0, count_reg} > 32'(MAX_FRAMES)) begin
            last_w = AW'(MAX_FRAMES - 1);
        end else begin
            last_w = AW'(count_reg - 7'd1);
        end
        dur_w    = (duration_reg == '0) ? 16'd1 : duration_reg;
        end_prod = MUL_W'(last_w) * MUL_W'(dur_w);
        end_w    = (64'(end_prod) > 64'(POS_MAX)) ? POS_MAX : POS_W'(end_prod);

        trial = {rem_reg, fi_reg[AW-1]};
        fits  = (trial >= {1'b0, dur_reg});
        sub   = trial - {1'b0, dur_reg};

        sum      = {1'b0, pos_reg} + (POS_W + 1)'(delta_reg);
        over     = (sum > {1'b0, end_reg});
        pos_next = run_reg ? (over ? end_reg : sum[POS_W-1:0]) : pos_reg;
        run_next = run_reg & ~over;

        out_free = !m_valid_reg || m_ready;
        write_ok = ({26'b0, s_frame_index} < 32'(MAX_FRAMES));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = fi_reg;
        mem_wdata = write_word;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = magenta_word;
            end
            ST_IDLE: begin
                mem_addr = AW'(s_frame_index);
                mem_we   = s_valid && (s_op == OP_WRITE) && write_ok;
            end
            ST_RDB: begin
                mem_addr = at_end_reg ? fi_reg : (fi_reg + AW'(1));
            end
            default: begin
                mem_addr = fi_reg;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
            run_reg      <= 1'b0;
            count_reg    <= COUNT_RESET;
            duration_reg <= DUR_RESET;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT: count_reg    <= cfg_wdata[COUNT_W-1:0];
                    CFG_FRAME_SPAN:  duration_reg <= cfg_wdata;
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_FRAMES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_op == OP_START) begin
                            pos_reg <= '0;
                            run_reg <= 1'b1;
                        end else if (s_op == OP_TICK) begin
                            delta_reg <= s_delta_ms;
                            state_reg <= ST_END;
                        end
                    end
                end
                ST_END: begin
                    end_reg   <= end_w;
                    dur_reg   <= dur_w;
                    last_reg  <= last_w;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    step_reg <= '0;
                    if (pos_reg >= end_reg) begin
                        at_end_reg <= 1'b1;
                        fi_reg     <= last_reg;
                        rem_reg    <= '0;
                        state_reg  <= ST_RDA;
                    end else begin
                        at_end_reg <= 1'b0;
                        fi_reg     <= pos_reg[AW-1:0];
                        rem_reg    <= DUR_W'(pos_reg >> AW);
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= fits ? sub[DUR_W-1:0] : trial[DUR_W-1:0];
                    fi_reg   <= AW'({fi_reg, fits});
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(AW - 1)) begin
                        state_reg <= ST_RDA;
                    end
                end
                ST_RDA: begin
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    frame_a_reg <= mem_rdata;
                    state_reg   <= ST_MUL;
                end
                ST_MUL: begin
                    step_reg  <= '0;
                    state_reg <= ST_BLEND;
                end
                ST_BLEND: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(BLEND_STEPS - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        for (int c = 0; c < COLOUR_FIELDS; c++) begin
                            m_colour_reg[c] <= colour[c];
                        end
                        m_running_reg  <= run_next;
                        m_position_reg <= pos_next;
                        pos_reg        <= pos_next;
                        run_reg        <= run_next;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    kci_frame_mem #(
        .DEPTH  (MAX_FRAMES),
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_frame_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign lane_ctrl.mul  = (state_reg == ST_MUL);
    assign lane_ctrl.step = (state_reg == ST_BLEND);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        kci_blend_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .lvl_a    (frame_a_reg[c*LEVEL_W +: LEVEL_W]),
            .lvl_b    (mem_rdata[c*LEVEL_W +: LEVEL_W]),
            .offset   (rem_reg),
            .duration (dur_reg),
            .level    (lane_lvl[c])
        );
    end

    for (genvar c = 0; c < COLOUR_FIELDS; c++) begin : g_colour
        if (c < CHANNELS) begin : g_used
            assign colour[c] = lane_lvl[c];
        end else begin : g_unused
            assign colour[c] = '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_red       = m_colour_reg[0];
    assign m_out_green     = m_colour_reg[1];
    assign m_out_blue      = m_colour_reg[2];
    assign m_out_white_one = m_colour_reg[3];
    assign m_out_white_two = m_colour_reg[4];
    assign m_still_running = m_running_reg;
    assign m_position_ms   = m_position_reg;

`ifndef SYNTHESIS
    // Inside the timeline the frame split must leave a following frame to blend toward.
    a_frame_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDA && !at_end_reg) |-> (fi_reg < last_reg))
        else $error("frame index has no following keyframe");

    // The offset into a frame is always below the frame duration.
    a_offset_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDA) |-> (rem_reg < dur_reg))
        else $error("frame offset not below frame duration");

    // A tick word reaches the output stage only after the full blend sequence.
    a_blend_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && $past(state_reg) != ST_OUT) |->
        ($past(state_reg) == ST_BLEND))
        else $error("output stage entered without a finished blend");
`endif

endmodule

[rtl/core/kci_frame_mem.sv]
// Single-port keyframe memory with a registered read port.
`timescale 1ns / 1ps

module kci_frame_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 40
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/kci_blend_lane.sv]
// One colour channel: difference times offset, then an eight-step restoring divide.
`timescale 1ns / 1ps

module kci_blend_lane
    import kci_pkg::*;
(
    input  logic               aclk,
    input  lane_ctrl_t         ctrl,
    input  logic [LEVEL_W-1:0] lvl_a,
    input  logic [LEVEL_W-1:0] lvl_b,
    input  logic [DUR_W-1:0]   offset,
    input  logic [DUR_W-1:0]   duration,
    output logic [LEVEL_W-1:0] level
);

    localparam int PROD_W = LEVEL_W + DUR_W;

    logic [LEVEL_W-1:0] base_reg;
    logic               neg_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [LEVEL_W-1:0] quo_reg;

    logic [LEVEL_W-1:0] mag;
    logic [PROD_W-1:0]  prod;
    logic [DUR_W:0]     trial;
    logic [DUR_W:0]     sub;
    logic               fits;

    always_comb begin
        mag   = (lvl_b < lvl_a) ? (lvl_a - lvl_b) : (lvl_b - lvl_a);
        prod  = PROD_W'(mag) * PROD_W'(offset);
        trial = {rem_reg, quo_reg[LEVEL_W-1]};
        fits  = (trial >= {1'b0, duration});
        sub   = trial - {1'b0, duration};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            base_reg <= lvl_a;
            neg_reg  <= (lvl_b < lvl_a);
            rem_reg  <= prod[PROD_W-1:LEVEL_W];
            quo_reg  <= prod[LEVEL_W-1:0];
        end else if (ctrl.step) begin
            rem_reg <= fits ? sub[DUR_W-1:0] : trial[DUR_W-1:0];
            quo_reg <= {quo_reg[LEVEL_W-2:0], fits};
        end
    end

    assign level = neg_reg ? (base_reg - quo_reg) : (base_reg + quo_reg);

endmodule
